// File: rtl/core/pfm_pkg.sv
// Package for the page frame mapper: table sizes, derived widths, status codes
// and the priority encoders used by the free-frame search.
// No dependencies.
package pfm_pkg;

  // Table sizes (powers of two)
  localparam int MAX_PAGES  = 256;
  localparam int MAX_FRAMES = 256;

  // Derived widths
  localparam int PAGE_W = $clog2(MAX_PAGES);
  localparam int FRAME_W = $clog2(MAX_FRAMES);
  localparam int CFG_W = 9;
  localparam int CFG_IDX_W = 2;
  localparam int STATUS_W = 3;

  // Two-level free-frame search: groups of GRP_SIZE frames
  localparam int GRP_SIZE = 16;
  localparam int NUM_GRP = MAX_FRAMES / GRP_SIZE;
  localparam int BIT_W = $clog2(GRP_SIZE);
  localparam int GRP_W = FRAME_W - BIT_W;

  // Register reset and limits
  localparam logic [CFG_W-1:0] COUNT_RESET = CFG_W'(256);
  localparam logic [CFG_W-1:0] PAGE_LIMIT = CFG_W'(MAX_PAGES);
  localparam logic [CFG_W-1:0] FRAME_LIMIT = CFG_W'(MAX_FRAMES);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PAGE_COUNT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT = CFG_IDX_W'(1);

  // Request kinds
  localparam logic KIND_MAP = 1'b0;
  localparam logic KIND_UNMAP = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_NO_FRAME = 3'd1,
    ST_RANGE    = 3'd2,
    ST_MAPPED   = 3'd3,
    ST_UNMAPPED = 3'd4
  } status_e;

  // Lowest set bit of the group summary
  function automatic logic [GRP_W-1:0] lsb_grp(input logic [NUM_GRP-1:0] bits);
    logic [GRP_W-1:0] idx;
    idx = '0;
    for (int i = NUM_GRP - 1; i >= 0; i--) begin
      if (bits[i]) idx = GRP_W'(i);
    end
    return idx;
  endfunction

  // Lowest set bit inside one group
  function automatic logic [BIT_W-1:0] lsb_bit(input logic [GRP_SIZE-1:0] bits);
    logic [BIT_W-1:0] idx;
    idx = '0;
    for (int i = GRP_SIZE - 1; i >= 0; i--) begin
      if (bits[i]) idx = BIT_W'(i);
    end
    return idx;
  endfunction

endpackage

// File: rtl/core/page_frame_mapper.sv
// Page frame mapper top level: page table memory, valid bits, free-frame bitmap
// and the request sequencer. Depends on pfm_pkg.
//
// Each request (map or unmap of one page) yields one result (frame, status).
// The accept edge in S_IDLE latches the request and issues the page table read,
// S_SCAN scans the per-group free summary for the lowest group with a free
// frame, and S_EXEC picks the lowest free frame in that group, updates the
// table and bitmap and loads the output register. The registered page table
// read and the two-level free-frame search set these steps. The next request
// is accepted while a result waits in the output register; S_EXEC stretches
// only while that register is still full and not being taken. Valid bits
// (cleared) and the bitmap (set to all free) sit in flip-flops set by reset,
// so no clearing pass is needed. Configuration writes take effect at once.
module page_frame_mapper
  import pfm_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  // request channel
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 kind_i,
  input  logic [PAGE_W-1:0]    page_i,
  // result channel
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [FRAME_W-1:0]   frame_o,
  output logic [STATUS_W-1:0]  status_o
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_EXEC = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [CFG_W-1:0]      page_cnt_q, frame_cnt_q;
  logic [CFG_W-1:0]      npages, nframes;
  logic                  kind_q;
  logic [PAGE_W-1:0]     page_q;
  logic [MAX_PAGES-1:0]  valid_q;
  logic [MAX_FRAMES-1:0] free_q;
  logic [NUM_GRP-1:0]    grp_any;
  logic [GRP_W-1:0]      grp_q;
  logic                  any_q;
  logic [GRP_SIZE-1:0]   grp_bits;
  logic [FRAME_W-1:0]    pick_frame;
  logic [FRAME_W-1:0]    frame_mem [MAX_PAGES];
  logic [FRAME_W-1:0]    mem_rdata_q;
  logic                  out_valid_q;
  logic [FRAME_W-1:0]    frame_q;
  status_e               status_q;

  logic       in_fire, exec_fire;
  logic       page_ok, page_mapped;
  logic       map_ok, unmap_ok;
  status_e    res_status;
  logic [FRAME_W-1:0] res_frame;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire = in_valid_i && in_ready_o;
  assign exec_fire = (state_q == S_EXEC) && (!out_valid_q || out_ready_i);

  // Saturate the counts to the table sizes
  assign npages = (page_cnt_q > PAGE_LIMIT) ? PAGE_LIMIT : page_cnt_q;
  assign nframes = (frame_cnt_q > FRAME_LIMIT) ? FRAME_LIMIT : frame_cnt_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_cnt_q <= COUNT_RESET;
      frame_cnt_q <= COUNT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PAGE_COUNT: page_cnt_q <= cfg_wdata_i;
        CFG_FRAME_COUNT: frame_cnt_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Page table memory: read on accept, write on a successful map
  always_ff @(posedge clk_i) begin
    if (exec_fire && map_ok) begin
      frame_mem[page_q] <= pick_frame;
    end
    if (in_fire) begin
      mem_rdata_q <= frame_mem[page_i];
    end
  end

  // Per-group summary of free frames
  always_comb begin
    for (int g = 0; g < NUM_GRP; g++) begin
      grp_any[g] = |free_q[g*GRP_SIZE +: GRP_SIZE];
    end
  end

  // Second search level: lowest free frame in the chosen group
  assign grp_bits = free_q[grp_q*GRP_SIZE +: GRP_SIZE];
  assign pick_frame = {grp_q, lsb_bit(grp_bits)};

  // Decide the result
  assign page_ok = {1'b0, page_q} < npages;
  assign page_mapped = valid_q[page_q];
  assign map_ok = page_ok && (kind_q == KIND_MAP) && !page_mapped && any_q &&
                  ({{(CFG_W-FRAME_W){1'b0}}, pick_frame} < nframes);
  assign unmap_ok = page_ok && (kind_q == KIND_UNMAP) && page_mapped;

  always_comb begin
    res_frame = '0;
    if (!page_ok) begin
      res_status = ST_RANGE;
    end else if (kind_q == KIND_MAP) begin
      if (page_mapped) begin
        res_status = ST_MAPPED;
      end else if (!map_ok) begin
        res_status = ST_NO_FRAME;
      end else begin
        res_status = ST_OK;
        res_frame = pick_frame;
      end
    end else begin
      if (!page_mapped) begin
        res_status = ST_UNMAPPED;
      end else begin
        res_status = ST_OK;
        res_frame = mem_rdata_q;
      end
    end
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (in_fire) state_d = S_SCAN;
      S_SCAN: state_d = S_EXEC;
      S_EXEC: if (exec_fire) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Latch the request; first search level in the scan cycle
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      kind_q <= kind_i;
      page_q <= page_i;
    end
    if (state_q == S_SCAN) begin
      grp_q <= lsb_grp(grp_any);
      any_q <= |grp_any;
    end
  end

  // Valid bits and free bitmap
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      free_q <= '1;
    end else if (exec_fire) begin
      if (map_ok) begin
        valid_q[page_q] <= 1'b1;
        free_q[pick_frame] <= 1'b0;
      end else if (unmap_ok) begin
        valid_q[page_q] <= 1'b0;
        free_q[mem_rdata_q] <= 1'b1;
      end
    end
  end

  // Output register: hold until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (exec_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec_fire) begin
      frame_q <= res_frame;
      status_q <= res_status;
    end
  end

  assign out_valid_o = out_valid_q;
  assign frame_o = frame_q;
  assign status_o = status_q;

`ifndef NO_ASSERTIONS
  // A frame handed out by a map was free and inside the frame count
  a_map_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec_fire && map_ok |-> free_q[pick_frame] &&
      ({{(CFG_W-FRAME_W){1'b0}}, pick_frame} < nframes))
    else $error("map picked a frame that is not free");

  // A successful map leaves the page valid and the frame taken
  a_map_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec_fire && map_ok |=> valid_q[$past(page_q)] && !free_q[$past(pick_frame)])
    else $error("map did not update the table");

  // A successful unmap returns the frame to the pool
  a_unmap_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec_fire && unmap_ok |=> free_q[$past(mem_rdata_q)] && !valid_q[$past(page_q)])
    else $error("unmap did not release the frame");

  // Error results carry frame zero
  a_err_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_OK) |-> (frame_o == '0))
    else $error("error result with nonzero frame");
`endif

endmodule

// File: bench/page_frame_mapper_checker.sv
// Result checker for the page frame mapper: mirrors the page table, the free
// bitmap and the count registers, predicts each result and compares it.
// Depends on pfm_pkg.
module page_frame_mapper_checker
  import pfm_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  logic                 kind_i,
  input  logic [PAGE_W-1:0]    page_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  logic [FRAME_W-1:0]   frame_i,
  input  logic [STATUS_W-1:0]  status_i,
  output int                   failures_o,
  output int                   outstanding_o,
  output int                   checked_o,
  output int                   refused_o
);

  typedef struct packed {
    logic [FRAME_W-1:0] frame;
    status_e            status;
  } mapping_result_t;

  // Mirror of the block's state
  logic [CFG_W-1:0]   page_count_q;
  logic [CFG_W-1:0]   frame_count_q;
  logic [FRAME_W-1:0] page_frame [MAX_PAGES];
  logic               page_mapped [MAX_PAGES];
  logic               frame_free [MAX_FRAMES];

  mapping_result_t pending_results [$];
  int              fail_cnt;
  int              check_cnt;
  int              refuse_cnt;

  // Apply one request to the mirrored table and return the result it causes
  function automatic mapping_result_t apply_request(input logic kind,
                                                    input logic [PAGE_W-1:0] pg);
    mapping_result_t r;
    int npages;
    int nframes;
    int f;
    r.frame = '0;
    r.status = ST_OK;
    npages = (page_count_q > PAGE_LIMIT) ? MAX_PAGES : int'(page_count_q);
    nframes = (frame_count_q > FRAME_LIMIT) ? MAX_FRAMES : int'(frame_count_q);
    if (int'(pg) >= npages) begin
      r.status = ST_RANGE;
    end else if (kind == KIND_MAP) begin
      if (page_mapped[pg]) begin
        r.status = ST_MAPPED;
      end else begin
        // lowest free frame below the frame count
        f = nframes;
        for (int i = nframes - 1; i >= 0; i--) begin
          if (frame_free[i]) f = i;
        end
        if (f >= nframes) begin
          r.status = ST_NO_FRAME;
        end else begin
          frame_free[f] = 1'b0;
          page_frame[pg] = FRAME_W'(f);
          page_mapped[pg] = 1'b1;
          r.frame = FRAME_W'(f);
        end
      end
    end else if (!page_mapped[pg]) begin
      r.status = ST_UNMAPPED;
    end else begin
      // release the frame even if it now lies above the frame count
      r.frame = page_frame[pg];
      frame_free[page_frame[pg]] = 1'b1;
      page_mapped[pg] = 1'b0;
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    mapping_result_t want;
    if (!rst_ni) begin
      page_count_q = COUNT_RESET;
      frame_count_q = COUNT_RESET;
      for (int i = 0; i < MAX_PAGES; i++) begin
        page_mapped[i] = 1'b0;
        page_frame[i] = '0;
      end
      for (int i = 0; i < MAX_FRAMES; i++) frame_free[i] = 1'b1;
      pending_results.delete();
      fail_cnt = 0;
      check_cnt = 0;
      refuse_cnt = 0;
    end else begin
      // track register writes; unknown indexes are dropped
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_PAGE_COUNT) page_count_q = cfg_wdata_i;
        else if (cfg_idx_i == CFG_FRAME_COUNT) frame_count_q = cfg_wdata_i;
      end
      // compare a delivered result with the oldest prediction
      if (out_valid_i && out_ready_i) begin
        if (pending_results.size() == 0) begin
          fail_cnt++;
          $display("%0t: result with no request pending: frame %0d status %0d",
                   $time, frame_i, status_i);
        end else begin
          want = pending_results.pop_front();
          check_cnt++;
          if (want.status != ST_OK) refuse_cnt++;
          if (frame_i !== want.frame || status_i !== want.status) begin
            fail_cnt++;
            $display("%0t: mismatch: expected frame %0d status %0d, got frame %0d status %0d",
                     $time, want.frame, want.status, frame_i, status_i);
          end
        end
      end
      // predict each accepted request
      if (in_valid_i && in_ready_i)
        pending_results.push_back(apply_request(kind_i, page_i));
    end
    failures_o <= fail_cnt;
    outstanding_o <= pending_results.size();
    checked_o <= check_cnt;
    refused_o <= refuse_cnt;
  end

endmodule

// File: bench/page_frame_mapper_test.sv
// Top of the page frame mapper bench: clock, reset, register writes, request
// stimulus and result back-pressure, and the final verdict.
// Depends on pfm_pkg, page_frame_mapper and page_frame_mapper_checker.
module page_frame_mapper_test;
  import pfm_pkg::*;

  localparam int CLK_PERIOD = 10;
  localparam int SETTLE_CYCLES = 6;
  localparam int LIMIT_CYCLES = 300000;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = CFG_IDX_W'(3);

  logic                 clk_i;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_W-1:0]     cfg_wdata_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic                 kind_i = KIND_MAP;
  logic [PAGE_W-1:0]    page_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [FRAME_W-1:0]   frame_o;
  logic [STATUS_W-1:0]  status_o;

  int failures;
  int outstanding;
  int checked;
  int refused;
  int settings_used = 0;
  bit sender_eager = 1'b0;
  bit recv_eager = 1'b0;
  int stall_left = 0;

  page_frame_mapper dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .kind_i      (kind_i),
    .page_i      (page_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .frame_o     (frame_o),
    .status_o    (status_o)
  );

  page_frame_mapper_checker mapping_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .kind_i        (kind_i),
    .page_i        (page_i),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .frame_i       (frame_o),
    .status_i      (status_o),
    .failures_o    (failures),
    .outstanding_o (outstanding),
    .checked_o     (checked),
    .refused_o     (refused)
  );

  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  // Randomly stall the result side after each accepted result; never when recv_eager is set
  always @(posedge clk_i or negedge rst_ni) begin
    int stall;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_left <= 0;
    end else if (out_valid_o && out_ready_i) begin
      stall = recv_eager ? 0 : $urandom_range(0, 5);
      out_ready_i <= (stall == 0);
      stall_left <= stall;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready_i <= (stall_left == 1);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Offer one request after a random gap and hold it until accepted
  task automatic send_request(input logic kind, input logic [PAGE_W-1:0] pg);
    int gap;
    gap = sender_eager ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i <= kind;
    page_i <= pg;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // Stop sending and wait until every result is back
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Drain, then load both counts
  task automatic set_counts(input int pages, input int frames);
    drain_results();
    write_reg(CFG_PAGE_COUNT, CFG_W'(pages));
    write_reg(CFG_FRAME_COUNT, CFG_W'(frames));
    settings_used++;
  endtask

  // Random traffic under one setting; mostly pages inside the active range
  task automatic run_traffic(input int pages, input int frames, input int count,
                             input int map_pct, input int hold_at);
    int span;
    logic [PAGE_W-1:0] pg;
    logic kind;
    set_counts(pages, frames);
    span = (pages > MAX_PAGES) ? MAX_PAGES : pages;
    sender_eager = ($urandom_range(0, 3) == 0);
    recv_eager <= ($urandom_range(0, 3) == 0);
    for (int n = 0; n < count; n++) begin
      if (n == hold_at) drain_results();
      if (span == 0 || $urandom_range(0, 9) == 0) pg = PAGE_W'($urandom_range(0, 255));
      else pg = PAGE_W'($urandom_range(0, span - 1));
      kind = ($urandom_range(0, 99) < map_pct) ? KIND_MAP : KIND_UNMAP;
      send_request(kind, pg);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: frame zero, double map, unmap of empty page, top page
    send_request(KIND_MAP, 8'd0);
    send_request(KIND_MAP, 8'd0);
    send_request(KIND_MAP, 8'd255);
    send_request(KIND_UNMAP, 8'd7);
    send_request(KIND_UNMAP, 8'd0);
    send_request(KIND_MAP, 8'd3);
    // Out of range pages and an exhausted pool
    set_counts(4, 2);
    send_request(KIND_MAP, 8'd4);
    send_request(KIND_UNMAP, 8'd255);
    send_request(KIND_MAP, 8'd1);
    // Zero counts
    set_counts(4, 0);
    send_request(KIND_MAP, 8'd2);
    set_counts(0, 0);
    send_request(KIND_UNMAP, 8'd3);
    send_request(KIND_MAP, 8'd0);
    // Counts above the table size saturate
    set_counts(511, 511);
    send_request(KIND_MAP, 8'd200);
    send_request(KIND_UNMAP, 8'd255);
    // Lowered frame count still releases a frame above it
    set_counts(256, 1);
    send_request(KIND_UNMAP, 8'd200);
    send_request(KIND_MAP, 8'd10);
    // Writes to unused indexes are dropped
    drain_results();
    write_reg(CFG_SPARE_LO, 9'h000);
    write_reg(CFG_SPARE_HI, 9'h1FF);
    send_request(KIND_UNMAP, 8'd3);
    send_request(KIND_MAP, 8'd10);

    // Random: fill, drain, tight pools, saturation, zero counts, mixed
    run_traffic(256, 256, 300, 88, 150);
    run_traffic(256, 256, 220, 25, -1);
    run_traffic(9, 4, 150, 55, -1);
    run_traffic(1, 1, 60, 50, -1);
    run_traffic(511, 511, 100, 60, -1);
    run_traffic(0, 300, 40, 50, -1);
    run_traffic(16, 0, 60, 60, -1);
    for (int p = 0; p < 3; p++)
      run_traffic($urandom_range(1, 64), $urandom_range(1, 32), 80, 55, -1);

    drain_results();
    $display("Checked %0d map/unmap requests under %0d count settings.",
             checked, settings_used);
    $display("%0d granted, %0d refused with an error status.", checked - refused, refused);
    if (failures == 0 && outstanding == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Hard stop if the block hangs
  initial begin
    #(CLK_PERIOD * LIMIT_CYCLES);
    $display("Timed out with %0d results still pending.", outstanding);
    $display("== FAIL ==");
    $finish;
  end

endmodule

// File: page_frame_mapper.f
rtl/core/pfm_pkg.sv
rtl/core/page_frame_mapper.sv
bench/page_frame_mapper_checker.sv
bench/page_frame_mapper_test.sv
